[rtl/rmts_pkg.sv]
// Shared constants for the rate-monotonic tick scheduler.
// No dependencies; used by rmts_table and rate_monotonic_tick_scheduler_top.
package rmts_pkg;

  localparam int MaxTasksDefault  = 8;
  localparam int TimeWidthDefault = 16;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

endpackage

[rtl/rmts_table.sv]
// Task table memory: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset.
// Depends on rmts_pkg for default sizes.
module rmts_table #(
  parameter int DEPTH = rmts_pkg::MaxTasksDefault,
  parameter int WIDTH = 4 * rmts_pkg::TimeWidthDefault,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (valid[raddr]) begin
      rdata <= mem[raddr];
    end else begin
      rdata <= '0;
    end
  end

endmodule

[rtl/rate_monotonic_tick_scheduler_top.sv]
// Rate-monotonic tick scheduler top level; instantiates rmts_table.
// Depends on rmts_pkg for constants and default parameter values.
//
// A load (opcode 0) writes the task table while busy stays low. A tick (opcode 1)
// sweeps the task table twice through its single read port, once to check
// deadlines and choose the running task and once to write back the counters.
// Read data is registered and returns the cycle after its address. Each sweep
// covers the active task count limited to MAX_TASKS, and busy stays high through
// both sweeps and the report cycle. A tick that finds a new deadline miss skips
// the second sweep. Once a deadline miss is flagged, or with no active tasks,
// busy is high only for the report cycle. Every tick ends with a one-cycle
// result_valid strobe; the receiver cannot stall, so it must capture each
// result in the cycle it appears. The configuration port is ready only while
// no tick is in progress.
module rate_monotonic_tick_scheduler_top #(
  parameter int MAX_TASKS  = rmts_pkg::MaxTasksDefault,
  parameter int TIME_WIDTH = rmts_pkg::TimeWidthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        opcode,
  input  logic [2:0]  task_slot,
  input  logic [15:0] burst_time,
  input  logic [15:0] period_length,
  output logic        result_valid,
  output logic [31:0] slot_number,
  output logic        task_ran,
  output logic [2:0]  running_task,
  output logic        deadline_miss,
  output logic [2:0]  missed_task,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data
);

  localparam int TW = TIME_WIDTH;
  localparam int EW = 4 * TW;
  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CHECK  = 2'd1;
  localparam logic [1:0] S_UPDATE = 2'd2;
  localparam logic [1:0] S_REPORT = 2'd3;

  logic [1:0]    state;
  logic [3:0]    active_tasks;
  logic [CW-1:0] cnt;
  logic          rvalid;
  logic [IW-1:0] ridx;
  logic          found;
  logic [2:0]    miss_at;
  logic          ran;
  logic [IW-1:0] pick;
  logic [TW-1:0] best_period;
  logic          miss_flag;
  logic [2:0]    miss_index;
  logic [31:0]   slot_counter;

  logic [CW-1:0] live;
  logic [31:0]   active_ext;
  logic [31:0]   slot_ext;
  logic [31:0]   burst_ext;
  logic [31:0]   period_ext;
  logic [31:0]   ridx_ext;
  logic [31:0]   pick_ext;
  logic          slot_ok;
  logic          scan_more;
  logic          pass_done;

  logic          tbl_we;
  logic [IW-1:0] tbl_waddr;
  logic [EW-1:0] tbl_wdata;
  logic [EW-1:0] tbl_rdata;

  logic [TW-1:0] rd_burst;
  logic [TW-1:0] rd_period;
  logic [TW-1:0] rd_rem;
  logic [TW-1:0] rd_cd;
  logic [TW-1:0] rem_dec;
  logic [EW-1:0] upd_entry;

  always_comb begin
    active_ext = 32'(active_tasks);
    if (active_ext > 32'(MAX_TASKS)) begin
      live = CW'(MAX_TASKS);
    end else begin
      live = active_ext[CW-1:0];
    end
    scan_more = (cnt < live);
    pass_done = (cnt == live) && !rvalid;

    slot_ext   = 32'(task_slot);
    burst_ext  = 32'(burst_time);
    period_ext = 32'(period_length);
    ridx_ext   = 32'(ridx);
    pick_ext   = 32'(pick);
    slot_ok    = slot_ext < 32'(MAX_TASKS);

    rd_burst  = tbl_rdata[4*TW-1:3*TW];
    rd_period = tbl_rdata[3*TW-1:2*TW];
    rd_rem    = tbl_rdata[2*TW-1:TW];
    rd_cd     = tbl_rdata[TW-1:0];

    if (ran && (ridx == pick)) begin
      rem_dec = rd_rem - TW'(1);
    end else begin
      rem_dec = rd_rem;
    end
    if (rd_cd <= TW'(1)) begin
      upd_entry = {rd_burst, rd_period, rd_burst, rd_period};
    end else begin
      upd_entry = {rd_burst, rd_period, rem_dec, rd_cd - TW'(1)};
    end

    if (state == S_UPDATE) begin
      tbl_we    = rvalid;
      tbl_waddr = ridx;
      tbl_wdata = upd_entry;
    end else begin
      tbl_we    = (state == S_IDLE) && start && (opcode == rmts_pkg::OP_LOAD) && slot_ok;
      tbl_waddr = slot_ext[IW-1:0];
      tbl_wdata = {burst_ext[TW-1:0], period_ext[TW-1:0],
                   burst_ext[TW-1:0], period_ext[TW-1:0]};
    end
  end

  rmts_table #(
    .DEPTH (MAX_TASKS),
    .WIDTH (EW)
  ) u_table (
    .clk   (clk),
    .rst   (rst),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (cnt[IW-1:0]),
    .rdata (tbl_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      active_tasks <= 4'd1;
      cnt          <= '0;
      rvalid       <= 1'b0;
      found        <= 1'b0;
      ran          <= 1'b0;
      pick         <= '0;
      miss_flag    <= 1'b0;
      miss_index   <= 3'd0;
      slot_counter <= 32'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        active_tasks <= cfg_data;
      end
      rvalid <= ((state == S_CHECK) || (state == S_UPDATE)) && scan_more;
      if (((state == S_CHECK) || (state == S_UPDATE)) && scan_more) begin
        ridx   <= cnt[IW-1:0];
        cnt    <= cnt + CW'(1);
      end
      case (state)
        S_IDLE: begin
          if (start && (opcode == rmts_pkg::OP_TICK)) begin
            ran   <= 1'b0;
            pick  <= '0;
            found <= 1'b0;
            cnt   <= '0;
            if (miss_flag || (live == '0)) begin
              state <= S_REPORT;
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (rvalid) begin
            if (!found && (rd_rem > rd_cd)) begin
              found   <= 1'b1;
              miss_at <= ridx_ext[2:0];
            end
            if ((rd_rem != '0) && (!ran || (rd_period < best_period))) begin
              ran         <= 1'b1;
              pick        <= ridx;
              best_period <= rd_period;
            end
          end
          if (pass_done) begin
            if (found) begin
              miss_flag  <= 1'b1;
              miss_index <= miss_at;
              ran        <= 1'b0;
              state      <= S_REPORT;
            end else begin
              cnt   <= '0;
              state <= S_UPDATE;
            end
          end
        end
        S_UPDATE: begin
          if (pass_done) begin
            state <= S_REPORT;
          end
        end
        S_REPORT: begin
          slot_counter <= slot_counter + 32'd1;
          state        <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy          = (state != S_IDLE);
  assign cfg_ready     = (state == S_IDLE);
  assign result_valid  = (state == S_REPORT);
  assign slot_number   = slot_counter;
  assign task_ran      = ran;
  assign running_task  = ran ? pick_ext[2:0] : 3'd0;
  assign deadline_miss = miss_flag;
  assign missed_task   = miss_flag ? miss_index : 3'd0;

endmodule
